### hdl/nnfs_pkg.sv
`timescale 1ns / 1ps
package nnfs_pkg;

  localparam int DIM_W       = 11;
  localparam int COORD_W     = 10;
  localparam int PIX_W       = 16;
  localparam int POS_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int STEP_W      = 27;
  localparam int INDEX_W     = 17;
  localparam int MODE_W      = 2;
  localparam int REG_INDEX_W = 3;
  localparam int QUO_W       = DIM_W + FRAC_W;
  localparam int DIV_COUNT_W = $clog2(QUO_W + 1);

  localparam int MAX_DIMENSION         = 1024;
  localparam int DEFAULT_SOURCE_PIXELS = 131072;

  localparam logic [DIM_W-1:0] RESET_SOURCE_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0] RESET_SOURCE_HEIGHT = 11'd240;
  localparam logic [DIM_W-1:0] RESET_SCREEN_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0] RESET_SCREEN_HEIGHT = 11'd240;

  localparam logic [MODE_W-1:0] MODE_NATIVE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STRETCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIT     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FIT_ALT = 2'd3;

  localparam logic [MODE_W-1:0] RESET_SCALE_MODE = MODE_NATIVE;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_SCALE_MODE    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0]  source_width;
    logic [DIM_W-1:0]  source_height;
    logic [DIM_W-1:0]  screen_width;
    logic [DIM_W-1:0]  screen_height;
    logic [MODE_W-1:0] scale_mode;
  } cfg_regs_t;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [COORD_W-1:0] image_left;
    logic [COORD_W-1:0] image_top;
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
  } geom_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_RATIO_W,
    G_RATIO_H,
    G_SIZE,
    G_STEP_X,
    G_STEP_Y,
    G_PLACE
  } geom_state_t;

  typedef enum logic [2:0] {
    P_IDLE,
    P_GEOM,
    P_MUL,
    P_ADDR,
    P_OUT
  } pix_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/nnfs_div.sv
`timescale 1ns / 1ps
module nnfs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nnfs_pkg::QUO_W-1:0]    dividend,
  input  logic [nnfs_pkg::DIM_W-1:0]    divisor,
  output logic                          done,
  output logic [nnfs_pkg::QUO_W-1:0]    quotient
);

  logic [nnfs_pkg::QUO_W-1:0]       quo;
  logic [nnfs_pkg::DIM_W-1:0]       rem;
  logic [nnfs_pkg::DIM_W-1:0]       dvs;
  logic [nnfs_pkg::DIV_COUNT_W-1:0] count;
  logic [nnfs_pkg::DIM_W:0]         trial;
  logic [nnfs_pkg::DIM_W:0]         diff;
  logic                             fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quo[nnfs_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= nnfs_pkg::DIV_COUNT_W'(nnfs_pkg::QUO_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == nnfs_pkg::DIV_COUNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (count != '0) begin
      quo <= {quo[nnfs_pkg::QUO_W-2:0], fits};
      rem <= fits ? diff[nnfs_pkg::DIM_W-1:0] : trial[nnfs_pkg::DIM_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

### hdl/nnfs_geom.sv
`timescale 1ns / 1ps
module nnfs_geom (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  nnfs_pkg::cfg_regs_t regs,
  output logic                done,
  output nnfs_pkg::geom_t     geom
);

  nnfs_pkg::geom_state_t state, state_next;

  logic [nnfs_pkg::DIM_W-1:0]   cw, ch, csw, csh;
  logic [nnfs_pkg::DIM_W-1:0]   w, h, sw, sh;
  logic [nnfs_pkg::DIM_W-1:0]   nw, nh;
  logic [nnfs_pkg::QUO_W-1:0]   rw, rh;
  logic [nnfs_pkg::STEP_W-1:0]  step_x, step_y;
  logic [nnfs_pkg::COORD_W-1:0] left, top;
  logic [nnfs_pkg::DIM_W-1:0]   gap_x, gap_y;
  logic [nnfs_pkg::MODE_W-1:0]  eff_mode;
  logic                         native_fits;
  logic                         wide_fit;
  logic                         issued;
  logic                         div_need;
  logic                         div_start;
  logic                         div_done;
  logic [nnfs_pkg::QUO_W-1:0]   div_dividend;
  logic [nnfs_pkg::DIM_W-1:0]   div_divisor;
  logic [nnfs_pkg::QUO_W-1:0]   div_quotient;
  logic [nnfs_pkg::DIM_W-1:0]   size_a, size_b;
  logic [2*nnfs_pkg::DIM_W-1:0] size_prod;

  assign cw  = nnfs_pkg::clamp_dim(regs.source_width);
  assign ch  = nnfs_pkg::clamp_dim(regs.source_height);
  assign csw = nnfs_pkg::clamp_dim(regs.screen_width);
  assign csh = nnfs_pkg::clamp_dim(regs.screen_height);
  assign native_fits = (cw <= csw) && (ch <= csh);

  always_comb begin
    case (regs.scale_mode) inside
      nnfs_pkg::MODE_NATIVE: eff_mode = native_fits ? nnfs_pkg::MODE_NATIVE
                                                    : nnfs_pkg::MODE_FIT;
      nnfs_pkg::MODE_STRETCH: eff_mode = nnfs_pkg::MODE_STRETCH;
      nnfs_pkg::MODE_FIT, nnfs_pkg::MODE_FIT_ALT: eff_mode = nnfs_pkg::MODE_FIT;
      default: eff_mode = nnfs_pkg::MODE_FIT;
    endcase
  end

  // fit: wider screen ratio means height limited
  assign wide_fit  = rw > rh;
  assign size_a    = wide_fit ? w : h;
  assign size_b    = wide_fit ? sh : sw;
  assign size_prod = size_a * size_b;

  always_comb begin
    state_next = state;
    unique case (state)
      nnfs_pkg::G_IDLE: begin
        if (go) begin
          state_next = (eff_mode == nnfs_pkg::MODE_FIT) ? nnfs_pkg::G_RATIO_W
                                                        : nnfs_pkg::G_STEP_X;
        end
      end
      nnfs_pkg::G_RATIO_W: if (div_done) state_next = nnfs_pkg::G_RATIO_H;
      nnfs_pkg::G_RATIO_H: if (div_done) state_next = nnfs_pkg::G_SIZE;
      nnfs_pkg::G_SIZE:    if (div_done) state_next = nnfs_pkg::G_STEP_X;
      nnfs_pkg::G_STEP_X: begin
        if (nw == '0 || div_done) state_next = nnfs_pkg::G_STEP_Y;
      end
      nnfs_pkg::G_STEP_Y: begin
        if (nh == '0 || div_done) state_next = nnfs_pkg::G_PLACE;
      end
      nnfs_pkg::G_PLACE: state_next = nnfs_pkg::G_IDLE;
      default: state_next = nnfs_pkg::G_IDLE;
    endcase
  end

  always_comb begin
    div_need     = 1'b0;
    done         = 1'b0;
    div_dividend = '0;
    div_divisor  = nnfs_pkg::DIM_W'(1);
    unique case (state)
      nnfs_pkg::G_IDLE: begin
      end
      nnfs_pkg::G_RATIO_W: begin
        div_need     = 1'b1;
        div_dividend = {sw, nnfs_pkg::FRAC_W'(0)};
        div_divisor  = w;
      end
      nnfs_pkg::G_RATIO_H: begin
        div_need     = 1'b1;
        div_dividend = {sh, nnfs_pkg::FRAC_W'(0)};
        div_divisor  = h;
      end
      nnfs_pkg::G_SIZE: begin
        div_need     = 1'b1;
        div_dividend = nnfs_pkg::QUO_W'(size_prod);
        div_divisor  = wide_fit ? h : w;
      end
      nnfs_pkg::G_STEP_X: begin
        div_need     = nw != '0;
        div_dividend = {w, nnfs_pkg::FRAC_W'(0)};
        div_divisor  = nw;
      end
      nnfs_pkg::G_STEP_Y: begin
        div_need     = nh != '0;
        div_dividend = {h, nnfs_pkg::FRAC_W'(0)};
        div_divisor  = nh;
      end
      nnfs_pkg::G_PLACE: done = 1'b1;
      default: begin
      end
    endcase
  end

  assign div_start = div_need && !issued;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= nnfs_pkg::G_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (div_done) begin
        issued <= 1'b0;
      end else if (div_start) begin
        issued <= 1'b1;
      end
    end
  end

  assign gap_x = sw - nw;
  assign gap_y = sh - nh;

  always_ff @(posedge clk) begin
    if (state == nnfs_pkg::G_IDLE && go) begin
      w  <= cw;
      h  <= ch;
      sw <= csw;
      sh <= csh;
      nw <= (eff_mode == nnfs_pkg::MODE_STRETCH) ? csw : cw;
      nh <= (eff_mode == nnfs_pkg::MODE_STRETCH) ? csh : ch;
    end
    if (div_done) begin
      case (state)
        nnfs_pkg::G_RATIO_W: rw <= div_quotient;
        nnfs_pkg::G_RATIO_H: rh <= div_quotient;
        nnfs_pkg::G_SIZE: begin
          if (wide_fit) begin
            nw <= div_quotient[nnfs_pkg::DIM_W-1:0];
            nh <= sh;
          end else begin
            nw <= sw;
            nh <= div_quotient[nnfs_pkg::DIM_W-1:0];
          end
        end
        nnfs_pkg::G_STEP_X: step_x <= div_quotient;
        nnfs_pkg::G_STEP_Y: step_y <= div_quotient;
        default: begin
        end
      endcase
    end
    if (state == nnfs_pkg::G_STEP_X && nw == '0) begin
      step_x <= '0;
    end
    if (state == nnfs_pkg::G_STEP_Y && nh == '0) begin
      step_y <= '0;
    end
    if (state == nnfs_pkg::G_PLACE) begin
      left <= gap_x[nnfs_pkg::DIM_W-1:1];
      top  <= gap_y[nnfs_pkg::DIM_W-1:1];
    end
  end

  nnfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign geom.image_width  = nw;
  assign geom.image_height = nh;
  assign geom.image_left   = left;
  assign geom.image_top    = top;
  assign geom.step_x       = step_x;
  assign geom.step_y       = step_y;

endmodule

### hdl/nnfs_store.sv
`timescale 1ns / 1ps
module nnfs_store #(
  parameter int SOURCE_PIXELS = nnfs_pkg::DEFAULT_SOURCE_PIXELS,
  parameter int ADDR_W        = (SOURCE_PIXELS > 1) ? $clog2(SOURCE_PIXELS) : 1
) (
  input  logic                         clk,
  input  logic                         write_en,
  input  logic [ADDR_W-1:0]            write_addr,
  input  logic [nnfs_pkg::PIX_W-1:0]   write_data,
  input  logic                         read_en,
  input  logic [ADDR_W-1:0]            read_addr,
  output logic [nnfs_pkg::PIX_W-1:0]   read_data
);

  logic [nnfs_pkg::PIX_W-1:0] mem [SOURCE_PIXELS];

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (read_en) begin
      read_data <= mem[read_addr];
    end
  end

endmodule

### hdl/nearest_neighbor_frame_scaler.sv
`timescale 1ns / 1ps
// write beat (kind 0): written to the store on accept, no result; busy stays low
// request beat (kind 1): multiply, store read, then output with the result strobe; the next beat
// may start in the strobe cycle
// first pixel of a frame first waits for the geometry, computed by the serial divider
// (up to five 27-bit divisions, one quotient bit per cycle); receiver can't stall
// rst (synchronous) clears counters and positions and loads default registers, store undefined
module nearest_neighbor_frame_scaler #(
  parameter int SOURCE_PIXELS = nnfs_pkg::DEFAULT_SOURCE_PIXELS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [nnfs_pkg::INDEX_W-1:0]       source_index,
  input  logic [nnfs_pkg::PIX_W-1:0]         pixel_in,
  input  logic                               cfg_write,
  input  logic [nnfs_pkg::REG_INDEX_W-1:0]   cfg_index,
  input  logic [nnfs_pkg::DIM_W-1:0]         cfg_data,
  output logic                               strobe,
  output logic [nnfs_pkg::PIX_W-1:0]         pixel_out,
  output logic [nnfs_pkg::COORD_W-1:0]       screen_x,
  output logic [nnfs_pkg::COORD_W-1:0]       screen_y,
  output logic                               frame_end
);

  localparam int ADDR_W = (SOURCE_PIXELS > 1) ? $clog2(SOURCE_PIXELS) : 1;
  localparam int PROD_W = nnfs_pkg::FRAC_W + nnfs_pkg::DIM_W;
  localparam int IDX_W  = PROD_W + 1;
  localparam int EXT_W  = nnfs_pkg::DIM_W + 1;

  nnfs_pkg::pix_state_t state, state_next;
  nnfs_pkg::cfg_regs_t  regs;
  nnfs_pkg::geom_t      geom;

  logic [nnfs_pkg::COORD_W-1:0] column_counter, row_counter;
  logic [nnfs_pkg::POS_W-1:0]   column_position, row_position;
  logic [PROD_W-1:0]            prod;
  logic [PROD_W-1:0]            mul_prod;
  logic [nnfs_pkg::FRAC_W-1:0]  src_col;
  logic [IDX_W-1:0]             src_idx;
  logic                         in_image, in_rows;
  logic                         in_image_now, in_rows_now;
  logic                         rd_ok;
  logic [nnfs_pkg::COORD_W-1:0] out_x, out_y;
  logic                         out_end;
  logic [nnfs_pkg::DIM_W-1:0]   src_w, sw, sh;
  logic [EXT_W-1:0]             x_ext, y_ext;
  logic                         row_end, frame_last;
  logic                         accept, accept_req, accept_write, frame_start;
  logic                         geom_go, geom_done;
  logic                         write_en, read_en, idx_in_range;
  logic [ADDR_W-1:0]            write_addr;
  logic [nnfs_pkg::PIX_W-1:0]   read_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.source_width  <= nnfs_pkg::RESET_SOURCE_WIDTH;
      regs.source_height <= nnfs_pkg::RESET_SOURCE_HEIGHT;
      regs.screen_width  <= nnfs_pkg::RESET_SCREEN_WIDTH;
      regs.screen_height <= nnfs_pkg::RESET_SCREEN_HEIGHT;
      regs.scale_mode    <= nnfs_pkg::RESET_SCALE_MODE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nnfs_pkg::REG_SOURCE_WIDTH:  regs.source_width  <= cfg_data;
        nnfs_pkg::REG_SOURCE_HEIGHT: regs.source_height <= cfg_data;
        nnfs_pkg::REG_SCREEN_WIDTH:  regs.screen_width  <= cfg_data;
        nnfs_pkg::REG_SCREEN_HEIGHT: regs.screen_height <= cfg_data;
        nnfs_pkg::REG_SCALE_MODE:    regs.scale_mode    <= cfg_data[nnfs_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept       = start && !busy;
  assign accept_req   = accept && kind;
  assign accept_write = accept && !kind;
  assign frame_start  = (column_counter == '0) && (row_counter == '0);
  assign geom_go      = accept_req && frame_start;

  assign write_en   = accept_write && (32'(source_index) < 32'(SOURCE_PIXELS));
  assign write_addr = ADDR_W'(32'(source_index));

  assign src_w = nnfs_pkg::clamp_dim(regs.source_width);
  assign sw    = nnfs_pkg::clamp_dim(regs.screen_width);
  assign sh    = nnfs_pkg::clamp_dim(regs.screen_height);

  assign x_ext = EXT_W'(column_counter);
  assign y_ext = EXT_W'(row_counter);
  assign in_rows_now = (y_ext >= EXT_W'(geom.image_top)) &&
                       (y_ext < EXT_W'(geom.image_top) + EXT_W'(geom.image_height));
  assign in_image_now = in_rows_now && (x_ext >= EXT_W'(geom.image_left)) &&
                        (x_ext < EXT_W'(geom.image_left) + EXT_W'(geom.image_width));

  assign mul_prod = row_position[nnfs_pkg::POS_W-1:nnfs_pkg::FRAC_W] * src_w;
  assign src_idx  = IDX_W'(prod) + IDX_W'(src_col);
  assign idx_in_range = 32'(src_idx) < 32'(SOURCE_PIXELS);

  assign row_end    = (nnfs_pkg::DIM_W'(column_counter) + 1'b1) >= sw;
  assign frame_last = (nnfs_pkg::DIM_W'(row_counter) + 1'b1) >= sh;

  always_comb begin
    state_next = state;
    unique case (state) inside
      nnfs_pkg::P_IDLE, nnfs_pkg::P_OUT: begin
        if (accept_req) begin
          state_next = frame_start ? nnfs_pkg::P_GEOM : nnfs_pkg::P_MUL;
        end else begin
          state_next = nnfs_pkg::P_IDLE;
        end
      end
      nnfs_pkg::P_GEOM: if (geom_done) state_next = nnfs_pkg::P_MUL;
      nnfs_pkg::P_MUL:  state_next = nnfs_pkg::P_ADDR;
      nnfs_pkg::P_ADDR: state_next = nnfs_pkg::P_OUT;
      default: state_next = nnfs_pkg::P_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    strobe  = 1'b0;
    read_en = 1'b0;
    unique case (state) inside
      nnfs_pkg::P_IDLE: begin
      end
      nnfs_pkg::P_GEOM, nnfs_pkg::P_MUL: busy = 1'b1;
      nnfs_pkg::P_ADDR: begin
        busy    = 1'b1;
        read_en = 1'b1;
      end
      nnfs_pkg::P_OUT: strobe = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= nnfs_pkg::P_IDLE;
      column_counter  <= '0;
      row_counter     <= '0;
      column_position <= '0;
      row_position    <= '0;
    end else begin
      state <= state_next;
      if (geom_go) begin
        column_position <= '0;
        row_position    <= '0;
      end else if (state == nnfs_pkg::P_ADDR) begin
        if (row_end) begin
          column_position <= '0;
          column_counter  <= '0;
          if (in_rows) begin
            row_position <= row_position + nnfs_pkg::POS_W'(geom.step_y);
          end
          row_counter <= frame_last ? '0 : row_counter + 1'b1;
        end else begin
          if (in_image) begin
            column_position <= column_position + nnfs_pkg::POS_W'(geom.step_x);
          end
          column_counter <= column_counter + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == nnfs_pkg::P_MUL) begin
      prod     <= mul_prod;
      src_col  <= column_position[nnfs_pkg::POS_W-1:nnfs_pkg::FRAC_W];
      in_image <= in_image_now;
      in_rows  <= in_rows_now;
    end
    if (state == nnfs_pkg::P_ADDR) begin
      rd_ok   <= in_image && idx_in_range;
      out_x   <= column_counter;
      out_y   <= row_counter;
      out_end <= row_end && frame_last;
    end
  end

  nnfs_geom u_geom (
    .clk  (clk),
    .rst  (rst),
    .go   (geom_go),
    .regs (regs),
    .done (geom_done),
    .geom (geom)
  );

  nnfs_store #(
    .SOURCE_PIXELS (SOURCE_PIXELS),
    .ADDR_W        (ADDR_W)
  ) u_store (
    .clk        (clk),
    .write_en   (write_en),
    .write_addr (write_addr),
    .write_data (pixel_in),
    .read_en    (read_en),
    .read_addr  (src_idx[ADDR_W-1:0]),
    .read_data  (read_data)
  );

  assign pixel_out = rd_ok ? read_data : '0;
  assign screen_x  = out_x;
  assign screen_y  = out_y;
  assign frame_end = out_end;

  a_req_result: assert property (@(posedge clk) disable iff (rst)
    (accept_req && !frame_start) |-> ##3 strobe)
    else $error("request beat without result");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (strobe && frame_end) |-> (column_counter == '0 && row_counter == '0))
    else $error("frame end without counter wrap");

  a_geom_done: assert property (@(posedge clk) disable iff (rst)
    geom_done |-> (state == nnfs_pkg::P_GEOM))
    else $error("geometry done outside geometry wait");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    read_en |-> !write_en)
    else $error("store read and write overlap");

endmodule
